// ===== rtl/core/texture_sampler_wrap_bilinear_core_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef TEXTURE_SAMPLER_WRAP_BILINEAR_CORE_MACROS_SVH
`define TEXTURE_SAMPLER_WRAP_BILINEAR_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TSW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define TSW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/tswb_pkg.sv =====
// ----------------------------------------------------------------------------
// tswb_pkg
// Shared types and constants of the texture sampler core.
// ----------------------------------------------------------------------------
package tswb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_FILTER = 3'd2;
    localparam logic [2:0] CFG_WRAPX  = 3'd3;
    localparam logic [2:0] CFG_WRAPY  = 3'd4;
    localparam logic [2:0] CFG_COMPS  = 3'd5;
    localparam logic [2:0] CFG_DEPTH  = 3'd6;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam int TEXEL_W = 64;
    localparam int CHAN_W  = 16;

    // Widen one loaded channel to 16-bit unorm.
    function automatic logic [15:0] widen(input logic [15:0] v, input logic depth16);
        logic [15:0] r;
        begin
            if (depth16) begin
                r = v;
            end else begin
                r = {v[7:0], v[7:0]};
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/tswb_ram.sv =====
// ----------------------------------------------------------------------------
// tswb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tswb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/tswb_axis.sv =====
// ----------------------------------------------------------------------------
// tswb_axis
// Coordinate scaling, floor/fraction split and wrap for one axis, two stages.
// ----------------------------------------------------------------------------
module tswb_axis #(
    parameter int MAXS = 256
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [31:0]        coord,
    input  logic [$clog2(MAXS+1)-1:0] size,
    input  logic                      repeat_mode,
    output logic [$clog2(MAXS)-1:0]   pos0,
    output logic [$clog2(MAXS)-1:0]   pos1,
    output logic [15:0]               frac
);
    localparam int SW = $clog2(MAXS + 1);
    localparam int PW = (MAXS > 1) ? $clog2(MAXS) : 1;
    localparam int MW = 33 + SW;
    localparam int IW = MW - 16;

    logic signed [MW-1:0] prod_reg, prod_next;
    logic [SW-1:0]        size_reg;
    logic                 rep_reg;
    logic [15:0]          coord_frac_reg;

    // Stage one: exact product of coordinate and size.
    assign prod_next = MW'(coord) * $signed({1'b0, size});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg       <= prod_next;
            size_reg       <= size;
            rep_reg        <= repeat_mode;
            coord_frac_reg <= coord[15:0];
        end
    end

    logic signed [IW-1:0] ipos;
    logic [SW-1:0]        m;
    logic [SW-1:0]        p0, p1;

    // Stage two: the floor is an arithmetic shift of the product. For repeat,
    // the integer part of the coordinate contributes a whole multiple of the
    // size, so the wrapped position is the fraction times the size, floored.
    always_comb begin
        ipos = prod_reg[MW-1:16];
        m    = SW'(({16'd0, coord_frac_reg} * {{16{1'b0}}, size_reg}) >> 16);
        if (rep_reg) begin
            p0 = m;
            p1 = (m + SW'(1) >= size_reg) ? '0 : m + SW'(1);
        end else begin
            if (ipos < 0) begin
                p0 = '0;
            end else if (ipos > $signed({1'b0, size_reg}) - 1) begin
                p0 = size_reg - SW'(1);
            end else begin
                p0 = SW'(ipos);
            end
            p1 = (p0 + SW'(1) >= size_reg) ? p0 : p0 + SW'(1);
        end
    end

    assign pos0 = PW'(p0);
    assign pos1 = PW'(p1);
    assign frac = prod_reg[15:0];
endmodule

// ===== rtl/core/texture_sampler_wrap_bilinear_core.sv =====
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_core
// Texel store with clamp/repeat wrapping and nearest or bilinear filtering.
// ----------------------------------------------------------------------------
// The core accepts one word per cycle while the result register is free or
// being taken: a load word writes one texel, a sample word returns one
// filtered RGBA word through the registered steps coordinate product,
// wrap and row address, store read, horizontal blend, then vertical blend
// into the result register. Four copies of the texel store give the four
// bilinear reads in the same cycle; every load writes all four copies. The
// pipeline stalls as a whole only when the result word is held. A load is
// written at the next advancing edge, so a sample sees every load accepted
// before it and none accepted after it.
module texture_sampler_wrap_bilinear_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_texel_index,
    input  logic [15:0] s_chan0,
    input  logic [15:0] s_chan1,
    input  logic [15:0] s_chan2,
    input  logic [15:0] s_chan3,
    input  logic signed [31:0] s_coord_u,
    input  logic signed [31:0] s_coord_v,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red,
    output logic [15:0] m_green,
    output logic [15:0] m_blue,
    output logic [15:0] m_alpha
);
    localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WSW   = $clog2(MAX_WIDTH + 1);
    localparam int HSW   = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [8:0] width_reg, height_reg;
    logic       filter_reg, wrapx_reg, wrapy_reg, depth_reg;
    logic [2:0] comps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            filter_reg <= 1'b1;
            wrapx_reg  <= 1'b1;
            wrapy_reg  <= 1'b1;
            comps_reg  <= 3'd4;
            depth_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tswb_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                tswb_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                tswb_pkg::CFG_FILTER: filter_reg <= cfg_data[0];
                tswb_pkg::CFG_WRAPX:  wrapx_reg  <= cfg_data[0];
                tswb_pkg::CFG_WRAPY:  wrapy_reg  <= cfg_data[0];
                tswb_pkg::CFG_COMPS:  comps_reg  <= cfg_data[2:0];
                tswb_pkg::CFG_DEPTH:  depth_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective sizes, limited to 1..maximum.
    logic [WSW-1:0] w_eff;
    logic [HSW-1:0] h_eff;
    always_comb begin
        if (width_reg == 9'd0) begin
            w_eff = WSW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WSW'(MAX_WIDTH);
        end else begin
            w_eff = WSW'(width_reg);
        end
        if (height_reg == 9'd0) begin
            h_eff = HSW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HSW'(MAX_HEIGHT);
        end else begin
            h_eff = HSW'(height_reg);
        end
    end

    // Pipeline control: four stages ahead of the result register, all
    // advancing together.
    localparam int NS = 4;
    logic [NS-1:0] vld_reg;
    logic          adv;
    logic [NS-1:0] flt_reg;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_valid && s_mode == tswb_pkg::MODE_SAMPLE};
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            flt_reg <= {flt_reg[NS-2:0], filter_reg};
        end
    end

    // Load path: build the texel for every bank copy.
    logic        ld_we;
    logic [63:0] ld_texel;
    logic [15:0] lr, lg, lb, la;
    always_comb begin
        lr = tswb_pkg::widen(s_chan0, depth_reg);
        lg = (comps_reg >= 3'd2) ? tswb_pkg::widen(s_chan1, depth_reg) : lr;
        lb = (comps_reg >= 3'd3) ? tswb_pkg::widen(s_chan2, depth_reg) : lr;
        la = (comps_reg >= 3'd4) ? tswb_pkg::widen(s_chan3, depth_reg) : 16'hFFFF;
        ld_texel = {la, lb, lg, lr};
        ld_we = s_valid && s_ready && s_mode == tswb_pkg::MODE_LOAD
                && 32'(s_texel_index) < DEPTH;
    end

    // The load is written at the next advancing edge, where any sample
    // accepted just before it has already taken its read.
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [63:0]   wr_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else if (adv) begin
            wr_pend_reg <= ld_we;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_addr_reg <= AW'(s_texel_index);
            wr_data_reg <= ld_texel;
        end
    end

    // Stages one and two: coordinate split and wrap per axis.
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [15:0]   fx, fy;

    tswb_axis #(.MAXS(MAX_WIDTH)) u_ax (
        .aclk(aclk), .en(adv), .coord(s_coord_u), .size(w_eff),
        .repeat_mode(wrapx_reg), .pos0(x0), .pos1(x1), .frac(fx)
    );
    tswb_axis #(.MAXS(MAX_HEIGHT)) u_ay (
        .aclk(aclk), .en(adv), .coord(s_coord_v), .size(h_eff),
        .repeat_mode(wrapy_reg), .pos0(y0), .pos1(y1), .frac(fy)
    );

    // Stage two to three: row products of the addresses.
    logic [AW-1:0] row0_reg, row1_reg;
    logic [XW-1:0] x0_reg, x1_reg;
    logic [15:0]   fx2_reg, fy2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            row0_reg <= AW'(32'(y0) * 32'(w_eff));
            row1_reg <= AW'(32'(y1) * 32'(w_eff));
            x0_reg   <= x0;
            x1_reg   <= x1;
            fx2_reg  <= fx;
            fy2_reg  <= fy;
        end
    end

    // Stage three: four addresses into the bank copies.
    logic [AW-1:0] ra [4];
    always_comb begin
        ra[0] = row0_reg + AW'(x0_reg);
        ra[1] = row0_reg + AW'(x1_reg);
        ra[2] = row1_reg + AW'(x0_reg);
        ra[3] = row1_reg + AW'(x1_reg);
    end

    logic [63:0]   rdata [4];
    logic [15:0]   fx3_reg, fy3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            fx3_reg   <= fx2_reg;
            fy3_reg   <= fy2_reg;
        end
    end

    // Stage four: bank reads; the read data holds during a stall.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        tswb_ram #(.WIDTH(tswb_pkg::TEXEL_W), .DEPTH(DEPTH)) u_ram (
            .aclk(aclk), .we(wr_pend_reg && adv), .waddr(wr_addr_reg),
            .wdata(wr_data_reg), .re(adv), .raddr(ra[b]),
            .rdata(rdata[b])
        );
    end

    // Stage five: horizontal blend per row.
    logic [32:0] h0_reg [4];
    logic [32:0] h1_reg [4];
    logic [63:0] near_reg;
    logic [15:0] fy5_reg;
    logic [16:0] wx0;
    assign wx0 = 17'd65536 - 17'(fx3_reg);
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                h0_reg[k] <= 33'(rdata[0][16*k +: 16] * wx0)
                           + 33'(rdata[1][16*k +: 16] * fx3_reg);
                h1_reg[k] <= 33'(rdata[2][16*k +: 16] * wx0)
                           + 33'(rdata[3][16*k +: 16] * fx3_reg);
            end
            near_reg <= rdata[0];
            fy5_reg  <= fy3_reg;
        end
    end

    // Stage six: vertical blend into the result register.
    logic        out_vld_reg;
    logic [63:0] out_reg;
    logic [16:0] wy0;
    logic [63:0] blend;
    assign wy0 = 17'd65536 - 17'(fy5_reg);
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            blend[16*k +: 16] = 16'((50'(h0_reg[k]) * 50'(wy0)
                                   + 50'(h1_reg[k]) * 50'(fy5_reg)) >> 32);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[NS-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= flt_reg[NS-1] ? blend : near_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_red   = out_reg[15:0];
    assign m_green = out_reg[31:16];
    assign m_blue  = out_reg[47:32];
    assign m_alpha = out_reg[63:48];
endmodule

// ===== rtl/core/tswb_checker.sv =====
// ----------------------------------------------------------------------------
// tswb_port_props
// Port-level checks of the texture sampler core, bound to the top level.
// ----------------------------------------------------------------------------
`include "texture_sampler_wrap_bilinear_core_macros.svh"
module tswb_port_props (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic [15:0] m_red
);
    // A waiting result word holds its value.
    `TSW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_red), "result word dropped")
    // Input is open whenever the output is empty.
    `TSW_ASSERT_IMPL(a_open, aclk, aresetn, !m_valid, s_ready, "input blocked with empty output")
    // Input stalls only behind a stalled result word.
    `TSW_ASSERT_IMPL(a_stall, aclk, aresetn, !s_ready, m_valid && !m_ready, "unexpected stall")
endmodule

bind texture_sampler_wrap_bilinear_core tswb_port_props u_tswb_port_props (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_red(m_red)
);

// ===== bench/tswb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tswb_checker
// Watches the configuration, input and result channels of the texture
// sampler core. It keeps its own copy of the texel store and the registers,
// predicts the filtered color of every accepted sample word, and compares
// each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module tswb_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_mode,
    input  logic [15:0]        s_texel_index,
    input  logic [15:0]        s_chan0,
    input  logic [15:0]        s_chan1,
    input  logic [15:0]        s_chan2,
    input  logic [15:0]        s_chan3,
    input  logic signed [31:0] s_coord_u,
    input  logic signed [31:0] s_coord_v,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [15:0]        m_red,
    input  logic [15:0]        m_green,
    input  logic [15:0]        m_blue,
    input  logic [15:0]        m_alpha,
    output int                 fail_count,
    output int                 pending,
    output int                 sample_count,
    output int                 load_count
);

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgba_t;

    rgba_t       color_q[$];
    logic [63:0] texel_mem[int];

    logic [8:0] width_reg, height_reg;
    logic       filter_reg, wrapx_reg, wrapy_reg, depth_reg;
    logic [2:0] comps_reg;

    // Register values of 0 act as 1, values above 256 act as 256.
    function automatic longint eff_size(input logic [8:0] v);
        if (v == 9'd0) begin
            return 1;
        end
        if (v > 9'd256) begin
            return 256;
        end
        return longint'(v);
    endfunction

    function automatic longint wrap_pos(input longint p, input longint size,
                                        input logic repeat_on);
        longint q;
        q = p;
        if (repeat_on) begin
            q = q % size;
            if (q < 0) begin
                q = q + size;
            end
        end else begin
            if (q < 0) begin
                q = 0;
            end
            if (q > size - 1) begin
                q = size - 1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] widen_chan(input logic [15:0] v);
        if (depth_reg) begin
            return v;
        end
        return 16'(v[7:0] * 16'd257);
    endfunction

    function automatic logic [63:0] fetch(input longint idx);
        if (texel_mem.exists(int'(idx))) begin
            return texel_mem[int'(idx)];
        end
        return 64'd0;
    endfunction

    // Scale both coordinates, wrap, and filter nearest or bilinear.
    function automatic rgba_t filter_color(input logic signed [31:0] cu,
                                           input logic signed [31:0] cv);
        longint w, h, prod_x, prod_y, ix, iy, ix1, iy1, fx, fy;
        longint row0, row1;
        logic [63:0] s00, s10, s01, s11;
        logic [63:0] acc;
        rgba_t res;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        prod_x = longint'(cu) * w;
        prod_y = longint'(cv) * h;
        fx = prod_x & 64'hFFFF;
        fy = prod_y & 64'hFFFF;
        ix = wrap_pos(prod_x >>> 16, w, wrapx_reg);
        iy = wrap_pos(prod_y >>> 16, h, wrapy_reg);
        s00 = fetch(ix + iy * w);
        if (!filter_reg) begin
            res = s00;
            return res;
        end
        ix1 = wrap_pos(ix + 1, w, wrapx_reg);
        iy1 = wrap_pos(iy + 1, h, wrapy_reg);
        s10 = fetch(ix1 + iy * w);
        s01 = fetch(ix + iy1 * w);
        s11 = fetch(ix1 + iy1 * w);
        for (int k = 0; k < 4; k++) begin
            row0 = longint'(s00[16*k +: 16]) * (65536 - fx)
                 + longint'(s10[16*k +: 16]) * fx;
            row1 = longint'(s01[16*k +: 16]) * (65536 - fx)
                 + longint'(s11[16*k +: 16]) * fx;
            acc = 64'(row0 * (65536 - fy) + row1 * fy);
            res[16*k +: 16] = acc[47:32];
        end
        return res;
    endfunction

    function automatic int check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Track register writes, loads, samples and result words at each edge.
    always @(posedge aclk) begin
        rgba_t       exp_c;
        logic [15:0] r, g, b, a;
        logic [2:0]  comps;
        int          errs;
        if (!aresetn) begin
            color_q.delete();
            texel_mem.delete();
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
            filter_reg   <= 1'b1;
            wrapx_reg    <= 1'b1;
            wrapy_reg    <= 1'b1;
            comps_reg    <= 3'd4;
            depth_reg    <= 1'b0;
            fail_count   <= 0;
            pending      <= 0;
            sample_count <= 0;
            load_count   <= 0;
        end else begin
            errs = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tswb_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    tswb_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    tswb_pkg::CFG_FILTER: filter_reg <= cfg_data[0];
                    tswb_pkg::CFG_WRAPX:  wrapx_reg  <= cfg_data[0];
                    tswb_pkg::CFG_WRAPY:  wrapy_reg  <= cfg_data[0];
                    tswb_pkg::CFG_COMPS:  comps_reg  <= cfg_data[2:0];
                    tswb_pkg::CFG_DEPTH:  depth_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_mode == tswb_pkg::MODE_LOAD) begin
                    // Missing green and blue copy red; missing alpha is full scale.
                    comps = (comps_reg == 3'd0) ? 3'd1 :
                            (comps_reg > 3'd4) ? 3'd4 : comps_reg;
                    r = widen_chan(s_chan0);
                    g = (comps >= 3'd2) ? widen_chan(s_chan1) : r;
                    b = (comps >= 3'd3) ? widen_chan(s_chan2) : r;
                    a = (comps >= 3'd4) ? widen_chan(s_chan3) : 16'hFFFF;
                    texel_mem[int'(s_texel_index)] = {a, b, g, r};
                    load_count <= load_count + 1;
                end else begin
                    color_q.push_back(filter_color(s_coord_u, s_coord_v));
                    sample_count <= sample_count + 1;
                end
            end
            if (m_valid && m_ready) begin
                if (color_q.size() == 0) begin
                    $error("result word with no sample outstanding");
                    errs = 1;
                end else begin
                    exp_c = color_q.pop_front();
                    errs += check_field("red", exp_c.red, m_red);
                    errs += check_field("green", exp_c.green, m_green);
                    errs += check_field("blue", exp_c.blue, m_blue);
                    errs += check_field("alpha", exp_c.alpha, m_alpha);
                end
            end
            fail_count <= fail_count + errs;
            pending    <= color_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the texture sampler core.
// Loads every texel a phase can read, then mixes samples and reloads under
// many register settings, with random idling on both channels and one long
// result stall. The checker module predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WORD_TARGET = 550;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [8:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = tswb_pkg::MODE_LOAD;
    logic [15:0]        s_texel_index = '0;
    logic [15:0]        s_chan0 = '0, s_chan1 = '0, s_chan2 = '0, s_chan3 = '0;
    logic signed [31:0] s_coord_u = '0, s_coord_v = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_red, m_green, m_blue, m_alpha;

    int fail_count, pending, sample_count, load_count;
    int words_sent = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit held = 1'b0;
    int cur_w, cur_h;

    texture_sampler_wrap_bilinear_core u_dut (.*);

    tswb_checker u_checker (.*);

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result receiver: random stall bursts, one long hold on request.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Offer one input word, with an optional idle burst first.
    task automatic send_word(input logic mode, input logic [15:0] idx,
                             input logic [63:0] chans,
                             input logic [31:0] cu, input logic [31:0] cv);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_texel_index <= idx;
        {s_chan3, s_chan2, s_chan1, s_chan0} <= chans;
        s_coord_u     <= cu;
        s_coord_v     <= cv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic load_texel(input int idx);
        send_word(tswb_pkg::MODE_LOAD, 16'(idx), {$urandom, $urandom}, $urandom, $urandom);
    endtask

    task automatic sample_at(input logic [31:0] cu, input logic [31:0] cv);
        send_word(tswb_pkg::MODE_SAMPLE, 16'($urandom), {$urandom, $urandom}, cu, cv);
    endtask

    // Wait for every result, then let the pipeline empty of loads.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write the whole register set while the core is idle.
    task automatic configure(input int w, input int h, input logic filt,
                             input logic wx, input logic wy,
                             input int comps, input logic depth);
        drain();
        write_reg(tswb_pkg::CFG_WIDTH, 9'(w));
        write_reg(tswb_pkg::CFG_HEIGHT, 9'(h));
        write_reg(tswb_pkg::CFG_FILTER, 9'(filt));
        write_reg(tswb_pkg::CFG_WRAPX, 9'(wx));
        write_reg(tswb_pkg::CFG_WRAPY, 9'(wy));
        write_reg(tswb_pkg::CFG_COMPS, 9'(comps));
        write_reg(tswb_pkg::CFG_DEPTH, 9'(depth));
        cfg_valid <= 1'b0;
        cur_w = (w == 0) ? 1 : (w > 256) ? 256 : w;
        cur_h = (h == 0) ? 1 : (h > 256) ? 256 : h;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
            default: return $urandom;
        endcase
    endfunction

    // Load the texels a full-size texture samples near its corner.
    task automatic load_corner();
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                load_texel(r * 256 + c);
            end
        end
    endtask

    initial begin
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: full size, bilinear, repeat, four 8-bit channels.
        // Only the corner is loaded, so samples stay near the origin.
        send_word(tswb_pkg::MODE_LOAD, 16'd0, 64'hFFFF_0000_FFFF_FF00, '0, '0);
        send_word(tswb_pkg::MODE_LOAD, 16'd1, 64'h0000_FFFF_0000_00FF, '0, '0);
        send_word(tswb_pkg::MODE_LOAD, 16'd256, 64'h1234_5678_9ABC_DEF0, '0, '0);
        send_word(tswb_pkg::MODE_LOAD, 16'd257, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        sample_at(32'd0, 32'd0);
        sample_at(32'd255, 32'd255);
        sample_at(32'd128, 32'd17);

        // Clamp, nearest, one 16-bit channel: extremes of the coordinates.
        configure(3, 2, 1'b0, 1'b0, 1'b0, 1, 1'b1);
        for (int i = 0; i < 6; i++) load_texel(i);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(32'hFFFF_FFFF, 32'h0001_0000);
        drain();
        write_reg(CFG_UNUSED, 9'h1FF);
        cfg_valid <= 1'b0;

        // Bilinear, repeat on both axes then on x only, two and three channels: negative wrap upward.
        configure(0, 3, 1'b1, 1'b1, 1'b1, 2, 1'b0);
        for (int i = 0; i < 3; i++) load_texel(i);
        sample_at(32'h8000_0000, 32'hFFFF_8000);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        configure(4, 4, 1'b1, 1'b1, 1'b0, 3, 1'b1);
        for (int i = 0; i < 16; i++) load_texel(i);
        sample_at(32'hFFFF_C000, 32'h0000_C000);
        send_word(tswb_pkg::MODE_LOAD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);

        // Random phases: each loads its whole region, then mixes words.
        while (words_sent < WORD_TARGET) begin
            case ($urandom_range(0, 9))
                0: configure(0, $urandom_range(0, 3), 1'($urandom), 1'($urandom),
                             1'($urandom), $urandom_range(0, 7), 1'($urandom));
                1: configure($urandom_range(9, 16), $urandom_range(1, 4), 1'($urandom),
                             1'($urandom), 1'($urandom), $urandom_range(0, 7),
                             1'($urandom));
                default: configure($urandom_range(1, 8), $urandom_range(1, 8),
                                   1'($urandom), 1'($urandom), 1'($urandom),
                                   $urandom_range(0, 7), 1'($urandom));
            endcase
            for (int i = 0; i < cur_w * cur_h; i++) load_texel(i);
            if (!held && words_sent > WORD_TARGET / 3) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            quiet = (words_sent > WORD_TARGET - 80);
            n = $urandom_range(20, 40);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0: load_texel($urandom_range(0, cur_w * cur_h - 1));
                    1: load_texel($urandom_range(0, 65535));
                    default: sample_at(rand_coord(), rand_coord());
                endcase
            end
        end

        // Full size again through an oversized width, clamped near the corner.
        configure(511, 256, 1'b1, 1'b0, 1'b0, 4, 1'b1);
        load_corner();
        for (int i = 0; i < 20; i++) begin
            sample_at(32'($signed($urandom_range(0, 70000)) - 69488),
                      32'($signed($urandom_range(0, 70000)) - 69488));
        end

        drain();
        $display("Covered %0d loads and %0d samples over many sizes, wrap modes,",
                 load_count, sample_count);
        $display("filters and load formats, with stalls on both channels.");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
